[design/prmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prmd_pkg
// types and constants for the press response mode detector
// ----------------------------------------------------------------------------
package prmd_pkg;

	localparam int COORD_BITS = 8;
	localparam int RESP_BITS  = 8;
	localparam int HOLD_BITS  = 10;
	localparam int CNT_BITS   = 8;
	localparam int CFG_BITS   = 10;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_RESPONSE_FRAMES   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_HOLDOUT_FRAMES    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CONFIRM_THRESHOLD = 2'd2;

	localparam logic [RESP_BITS-1:0] RESPONSE_FRAMES_RST   = 8'd8;
	localparam logic [HOLD_BITS-1:0] HOLDOUT_FRAMES_RST    = 10'd120;
	localparam logic [CNT_BITS-1:0]  CONFIRM_THRESHOLD_RST = 8'd2;
	localparam logic [CNT_BITS-1:0]  CNT_MAX               = 8'd255;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_DOWN  = 2'd2,
		DIR_UP    = 2'd3
	} dir_t;

	typedef struct packed {
		logic [3:0]            dpad_keys;
		logic                  cursor_found;
		logic [COORD_BITS-1:0] cursor_x;
		logic [COORD_BITS-1:0] cursor_y;
	} in_word_t;

	typedef struct packed {
		logic [CNT_BITS-1:0]  confirm_count;
		logic [HOLD_BITS-1:0] holdout_left;
		logic                 window_open;
		logic                 confirmed_now;
	} out_word_t;

endpackage

[design/press_response_mode_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// press_response_mode_detector
// counts cursor moves that answer fresh direction presses, with holdout
// ----------------------------------------------------------------------------
// channel   dir  handshake               payload
// in        in   in_valid / in_ready     in_data  (in_word_t)
// out       out  out_valid / out_ready   out_data (out_word_t)
// cfg       in   cfg_we                  cfg_index, cfg_data
//
// one word per cycle sustained while out_ready stays high; a word goes to out_data
// through the input register at accept, then the result register with the state update
// arst_n clears control state, counters and config registers to their reset values
// a stalled output holds its word; the input register still takes one more
// ----------------------------------------------------------------------------
module press_response_mode_detector
	import prmd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  in_word_t                in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output out_word_t               out_data,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	logic [RESP_BITS-1:0]  response_frames_q;
	logic [HOLD_BITS-1:0]  holdout_frames_q;
	logic [CNT_BITS-1:0]   confirm_threshold_q;

	logic                  valid_s1;
	in_word_t              word_s1;
	logic                  out_valid_q;
	out_word_t             out_word_q;

	logic [3:0]            prev_dpad_q;
	logic                  have_prev_q;
	logic [COORD_BITS-1:0] prev_x_q;
	logic [COORD_BITS-1:0] prev_y_q;
	dir_t                  pending_dir_q;
	logic [RESP_BITS-1:0]  window_q;
	logic [CNT_BITS-1:0]   confirm_q;
	logic [HOLD_BITS-1:0]  holdout_q;

	logic                  advance;
	logic [3:0]            newly;
	dir_t                  dir_n;
	logic [RESP_BITS-1:0]  window_a;
	logic [RESP_BITS-1:0]  window_n;
	logic                  match;
	logic                  confirmed;
	logic [CNT_BITS-1:0]   confirm_a;
	logic [CNT_BITS-1:0]   confirm_n;
	logic [HOLD_BITS-1:0]  holdout_a;
	logic [HOLD_BITS-1:0]  holdout_n;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			response_frames_q   <= RESPONSE_FRAMES_RST;
			holdout_frames_q    <= HOLDOUT_FRAMES_RST;
			confirm_threshold_q <= CONFIRM_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RESPONSE_FRAMES:   response_frames_q   <= cfg_data[RESP_BITS-1:0];
				REG_HOLDOUT_FRAMES:    holdout_frames_q    <= cfg_data[HOLD_BITS-1:0];
				REG_CONFIRM_THRESHOLD: confirm_threshold_q <= cfg_data[CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// next-state logic for the word in the input register
	always_comb begin
		newly     = word_s1.dpad_keys & ~prev_dpad_q;
		dir_n     = pending_dir_q;
		window_a  = window_q;
		if (newly != 4'd0) begin
			if (newly[0]) begin
				dir_n = DIR_RIGHT;
			end else if (newly[1]) begin
				dir_n = DIR_LEFT;
			end else if (newly[2]) begin
				dir_n = DIR_DOWN;
			end else begin
				dir_n = DIR_UP;
			end
			window_a = response_frames_q;
		end

		case (dir_n)
			DIR_RIGHT: match = word_s1.cursor_x > prev_x_q;
			DIR_LEFT:  match = word_s1.cursor_x < prev_x_q;
			DIR_DOWN:  match = word_s1.cursor_y > prev_y_q;
			default:   match = word_s1.cursor_y < prev_y_q;
		endcase

		confirmed = (window_a != '0) && word_s1.cursor_found && have_prev_q && match;
		window_n  = window_a;
		confirm_a = confirm_q;
		holdout_a = holdout_q;
		if (window_a != '0) begin
			window_n = window_a - 1'b1;
		end
		if (confirmed) begin
			window_n  = '0;
			holdout_a = holdout_frames_q;
			if (confirm_q != CNT_MAX) begin
				confirm_a = confirm_q + 1'b1;
			end
		end

		// holdout countdown once threshold is reached; the count clears when it expires
		confirm_n = confirm_a;
		holdout_n = holdout_a;
		if ((holdout_a != '0) && (confirm_a >= confirm_threshold_q)) begin
			holdout_n = holdout_a - 1'b1;
			if (holdout_n == '0) begin
				confirm_n = '0;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_data;
		end
	end

	// detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_dpad_q   <= '0;
			have_prev_q   <= 1'b0;
			prev_x_q      <= '0;
			prev_y_q      <= '0;
			pending_dir_q <= DIR_RIGHT;
			window_q      <= '0;
			confirm_q     <= '0;
			holdout_q     <= '0;
		end else if (advance) begin
			prev_dpad_q   <= word_s1.dpad_keys;
			pending_dir_q <= dir_n;
			window_q      <= window_n;
			confirm_q     <= confirm_n;
			holdout_q     <= holdout_n;
			if (word_s1.cursor_found) begin
				have_prev_q <= 1'b1;
				prev_x_q    <= word_s1.cursor_x;
				prev_y_q    <= word_s1.cursor_y;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q.confirm_count <= confirm_n;
			out_word_q.holdout_left  <= holdout_n;
			out_word_q.window_open   <= window_n != '0;
			out_word_q.confirmed_now <= confirmed;
		end
	end

	a_confirm_closes_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_word_q.confirmed_now && out_word_q.window_open))
		else $error("window still open after a confirmation");

	a_confirm_reloads_holdout: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_word_q.confirmed_now) |->
			(out_word_q.holdout_left == holdout_frames_q ||
			 out_word_q.holdout_left == holdout_frames_q - 1'b1))
		else $error("holdout not reloaded on confirmation");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with an empty result register");

endmodule

[dv/prmd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prmd_checker
// watches the in, out and cfg ports of the press response mode detector,
// mirrors its register file, predicts the status word of every accepted frame
// and compares each delivered word field by field, in order
// ----------------------------------------------------------------------------
module prmd_checker
	import prmd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  in_word_t                in_data,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  out_word_t               out_data,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	output int                      errors,
	output int                      pending,
	output int                      checked,
	output int                      confirms
);

	logic [RESP_BITS-1:0]  win_len;
	logic [HOLD_BITS-1:0]  hold_len;
	logic [CNT_BITS-1:0]   threshold;

	logic [3:0]            prev_keys;
	logic                  pos_known;
	logic [COORD_BITS-1:0] last_x;
	logic [COORD_BITS-1:0] last_y;
	dir_t                  armed_dir;
	logic [RESP_BITS-1:0]  window_left;
	logic [CNT_BITS-1:0]   confirm_cnt;
	logic [HOLD_BITS-1:0]  hold_left;

	out_word_t             expected_status[$];
	out_word_t             want;
	int                    err_count;
	int                    word_count;
	int                    hit_count;

	assign errors   = err_count;
	assign checked  = word_count;
	assign confirms = hit_count;

	function automatic out_word_t predict_frame(input in_word_t w);
		logic [3:0] fresh;
		logic       moved;
		logic       hit;
		out_word_t  r;
		fresh = w.dpad_keys & ~prev_keys;
		moved = 1'b0;
		hit   = 1'b0;
		if (fresh != 4'h0) begin
			if (fresh[0]) armed_dir = DIR_RIGHT;
			else if (fresh[1]) armed_dir = DIR_LEFT;
			else if (fresh[2]) armed_dir = DIR_DOWN;
			else armed_dir = DIR_UP;
			window_left = win_len;
		end
		if (window_left != 0) begin
			window_left--;
			if (w.cursor_found && pos_known) begin
				case (armed_dir)
					DIR_RIGHT: moved = w.cursor_x > last_x;
					DIR_LEFT:  moved = w.cursor_x < last_x;
					DIR_DOWN:  moved = w.cursor_y > last_y;
					default:   moved = w.cursor_y < last_y;
				endcase
				if (moved) begin
					if (confirm_cnt != CNT_MAX) confirm_cnt++;
					hold_left   = hold_len;
					window_left = '0;
					hit         = 1'b1;
				end
			end
		end
		if (hold_left != 0 && confirm_cnt >= threshold) begin
			hold_left--;
			if (hold_left == 0) confirm_cnt = '0;
		end
		prev_keys = w.dpad_keys;
		if (w.cursor_found) begin
			last_x    = w.cursor_x;
			last_y    = w.cursor_y;
			pos_known = 1'b1;
		end
		r.confirm_count = confirm_cnt;
		r.holdout_left  = hold_left;
		r.window_open   = window_left != 0;
		r.confirmed_now = hit;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len     = RESPONSE_FRAMES_RST;
			hold_len    = HOLDOUT_FRAMES_RST;
			threshold   = CONFIRM_THRESHOLD_RST;
			prev_keys   = '0;
			pos_known   = 1'b0;
			last_x      = '0;
			last_y      = '0;
			armed_dir   = DIR_RIGHT;
			window_left = '0;
			confirm_cnt = '0;
			hold_left   = '0;
			expected_status.delete();
			err_count   = 0;
			word_count  = 0;
			hit_count   = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_status.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("prmd_checker: unexpected word count=%0d hold=%0d open=%b hit=%b",
							out_data.confirm_count, out_data.holdout_left,
							out_data.window_open, out_data.confirmed_now);
				end else begin
					want = expected_status.pop_front();
					word_count++;
					if (out_data.confirmed_now) hit_count++;
					if (out_data.confirm_count !== want.confirm_count ||
						out_data.holdout_left !== want.holdout_left ||
						out_data.window_open !== want.window_open ||
						out_data.confirmed_now !== want.confirmed_now) begin
						err_count++;
						if (err_count <= 10) begin
							$write("prmd_checker: word %0d expected count=%0d hold=%0d open=%b hit=%b",
								word_count, want.confirm_count, want.holdout_left,
								want.window_open, want.confirmed_now);
							$display(", got count=%0d hold=%0d open=%b hit=%b",
								out_data.confirm_count, out_data.holdout_left,
								out_data.window_open, out_data.confirmed_now);
						end
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_RESPONSE_FRAMES:   win_len   = cfg_data[RESP_BITS-1:0];
					REG_HOLDOUT_FRAMES:    hold_len  = cfg_data[HOLD_BITS-1:0];
					REG_CONFIRM_THRESHOLD: threshold = cfg_data[CNT_BITS-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_status.push_back(predict_frame(in_data));
		end
		pending = expected_status.size();
	end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives frames and register writes into the press response mode detector;
// directed frames first, then press and cursor move gestures mixed with noise
// over several register settings, with random gaps and output stalls
// ----------------------------------------------------------------------------
module tb_top
	import prmd_pkg::*;
();

	localparam int LIMIT = 200000;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	in_word_t                in_data;
	logic                    out_valid;
	logic                    out_ready = 1'b1;
	out_word_t               out_data;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]     cfg_data;

	int                      errors;
	int                      pending;
	int                      checked;
	int                      confirms;

	int                      cycle_count = 0;
	int                      stall_left = 0;
	int                      sent = 0;
	int                      reg_writes = 0;
	bit                      calm = 1'b0;
	logic [3:0]              held_keys = '0;
	logic [7:0]              pos_x = '0;
	logic [7:0]              pos_y = '0;
	logic [7:0]              resp_now = RESPONSE_FRAMES_RST;

	press_response_mode_detector uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	prmd_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked),
		.confirms  (confirms)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// output stalls in short bursts
	always @(negedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 2);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_word(input in_word_t w);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 3);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		held_keys = w.dpad_keys;
		if (w.cursor_found) begin
			pos_x = w.cursor_x;
			pos_y = w.cursor_y;
		end
		sent++;
	endtask

	task automatic frame(input logic [3:0] keys, input logic found,
		input logic [7:0] x, input logic [7:0] y);
		in_word_t w;
		w.dpad_keys    = keys;
		w.cursor_found = found;
		w.cursor_x     = x;
		w.cursor_y     = y;
		send_word(w);
	endtask

	task automatic noise_frame();
		in_word_t w;
		w.dpad_keys    = 4'($urandom);
		w.cursor_found = 1'($urandom);
		w.cursor_x     = 8'($urandom);
		w.cursor_y     = 8'($urandom);
		send_word(w);
	endtask

	// fresh press of one direction, optional wait, then a matching move when hit is set
	task automatic gesture(input dir_t d, input int delay, input bit hit);
		logic [3:0] keys;
		logic [7:0] nx;
		logic [7:0] ny;
		int         i;
		if (held_keys[d]) frame(4'h0, 1'($urandom), pos_x, pos_y);
		keys = 4'h1 << d;
		if ($urandom_range(0, 3) == 0) keys = keys | (4'($urandom) & (4'hF << (d + 1)));
		for (i = 0; i < delay; i++) begin
			if ($urandom_range(0, 1) != 0) frame(keys, 1'b1, pos_x, pos_y);
			else frame(keys, 1'b0, 8'($urandom), 8'($urandom));
		end
		if (hit) begin
			nx = pos_x;
			ny = pos_y;
			case (d)
				DIR_RIGHT: if (pos_x != 8'hFF) nx = 8'($urandom_range(int'(pos_x) + 1, 255));
				DIR_LEFT:  if (pos_x != 8'h00) nx = 8'($urandom_range(0, int'(pos_x) - 1));
				DIR_DOWN:  if (pos_y != 8'hFF) ny = 8'($urandom_range(int'(pos_y) + 1, 255));
				default:   if (pos_y != 8'h00) ny = 8'($urandom_range(0, int'(pos_y) - 1));
			endcase
			if ($urandom_range(0, 1) != 0) begin
				if (d == DIR_RIGHT || d == DIR_LEFT) ny = 8'($urandom);
				else nx = 8'($urandom);
			end
			frame(keys, 1'b1, nx, ny);
		end
	endtask

	task automatic run_mix(input int n);
		int target;
		int span;
		target = sent + n;
		span   = (resp_now > 10) ? 10 : int'(resp_now) + 1;
		while (sent < target) begin
			if ($urandom_range(0, 9) < 2) noise_frame();
			else gesture(dir_t'($urandom_range(0, 3)), $urandom_range(0, span),
				$urandom_range(0, 4) != 0);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
	endtask

	task automatic set_regs(input logic [7:0] resp, input logic [9:0] hold, input logic [7:0] thr);
		drain();
		write_reg(REG_RESPONSE_FRAMES, {2'b00, resp});
		write_reg(REG_HOLDOUT_FRAMES, hold);
		write_reg(REG_CONFIRM_THRESHOLD, {2'b00, thr});
		resp_now = resp;
	endtask

	initial begin
		int   i;
		dir_t d;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed frames at reset settings
		frame(4'h0, 1'b0, 8'h00, 8'h00);
		frame(4'h1, 1'b1, 8'h00, 8'h00);   // press with no earlier position
		frame(4'h1, 1'b1, 8'hFF, 8'h00);   // right move
		frame(4'hF, 1'b1, 8'hFF, 8'hFF);   // several new keys, left wins
		frame(4'hF, 1'b0, 8'h00, 8'h00);   // cursor lost, position kept
		frame(4'hF, 1'b1, 8'h00, 8'hFF);   // left move, threshold reached
		frame(4'h0, 1'b1, 8'h00, 8'hFF);
		frame(4'h4, 1'b1, 8'h07, 8'h00);   // wrong way for down
		frame(4'h4, 1'b1, 8'h07, 8'hFF);   // down move
		frame(4'h8, 1'b1, 8'h07, 8'hFF);
		frame(4'h8, 1'b1, 8'h07, 8'h00);   // up move
		frame(4'h0, 1'b0, 8'hAA, 8'h55);
		frame(4'h2, 1'b1, 8'h07, 8'h00);
		for (i = 0; i < 7; i++) frame(4'h2, 1'b0, 8'h55, 8'hAA);
		frame(4'h2, 1'b1, 8'h00, 8'h00);   // window already closed
		frame(4'h3, 1'b1, 8'hC8, 8'h09);   // right added while left held
		frame(4'h0, 1'b1, 8'h64, 8'h64);

		set_regs(RESPONSE_FRAMES_RST, HOLDOUT_FRAMES_RST, CONFIRM_THRESHOLD_RST);
		run_mix(120);
		set_regs(8'd1, 10'd1, 8'd1);
		run_mix(120);
		set_regs(8'd0, 10'd0, 8'd0);
		run_mix(60);

		// count runs to saturation with no holdout to clear it
		set_regs(8'd255, 10'd0, 8'd0);
		d = DIR_RIGHT;
		for (i = 0; i < 270; i++) begin
			d = dir_t'((int'(d) + 1 + $urandom_range(0, 2)) % 4);
			gesture(d, 0, 1'b1);
		end
		set_regs(8'd255, 10'd1023, 8'd255);
		run_mix(120);
		set_regs(8'd3, 10'd5, 8'd1);
		run_mix(120);
		set_regs(8'($urandom), 10'($urandom), 8'($urandom_range(0, 4)));
		run_mix(100);
		set_regs(8'($urandom_range(1, 12)), 10'($urandom_range(1, 40)), 8'($urandom));
		run_mix(100);

		set_regs(RESPONSE_FRAMES_RST, HOLDOUT_FRAMES_RST, CONFIRM_THRESHOLD_RST);
		calm = 1'b1;
		run_mix(100);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		$display("tb_top: %0d frames sent, %0d status words checked, %0d register writes",
			sent, checked, reg_writes);
		$display("tb_top: %0d confirmations seen, %0d mismatches", confirms, errors);
		if (errors == 0 && pending == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

[sim.f]
design/prmd_pkg.sv
design/press_response_mode_detector.sv
dv/prmd_checker.sv
dv/tb_top.sv
